### hdl/pfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  // pixel formats; code three behaves as L8
  typedef enum logic [1:0] {
    FMT_L8   = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_YUY2 = 2'd2
  } fmt_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_FORMAT = 2'd1;

  // pixel counts of a result
  localparam logic [1:0] PC_ONE = 2'd1;
  localparam logic [1:0] PC_TWO = 2'd2;

  // YUV to RGB, 13-bit fraction
  localparam logic signed [15:0] K_Y  = 16'sd9535;
  localparam logic signed [15:0] K_RV = 16'sd13074;
  localparam logic signed [15:0] K_GV = 16'sd6660;
  localparam logic signed [15:0] K_GU = 16'sd3203;
  localparam logic signed [15:0] K_BU = 16'sd16531;

  // RGB to YUV, 13-bit fraction; sums always land in 0 .. 2^21-1
  localparam int unsigned YUV_SUM_W = 21;
  localparam logic [YUV_SUM_W-1:0] K_YR   = 21'd2104;
  localparam logic [YUV_SUM_W-1:0] K_YG   = 21'd4130;
  localparam logic [YUV_SUM_W-1:0] K_YB   = 21'd802;
  localparam logic [YUV_SUM_W-1:0] K_UR   = 21'd1214;
  localparam logic [YUV_SUM_W-1:0] K_UG   = 21'd2384;
  localparam logic [YUV_SUM_W-1:0] K_UB   = 21'd3598;
  localparam logic [YUV_SUM_W-1:0] K_VR   = 21'd3598;
  localparam logic [YUV_SUM_W-1:0] K_VG   = 21'd3013;
  localparam logic [YUV_SUM_W-1:0] K_VB   = 21'd585;
  localparam logic [YUV_SUM_W-1:0] OFS_Y  = 21'd135168;   // rounding + 16 << 13
  localparam logic [YUV_SUM_W-1:0] OFS_UV = 21'd1052672;  // rounding + 128 << 13
  localparam logic [7:0] Y_MAX  = 8'd235;
  localparam logic [7:0] UV_MAX = 8'd240;

  localparam int unsigned RGB_SUM_W = 25;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } pixel_t;

  function automatic fmt_t norm_fmt(input logic [1:0] f);
    fmt_t r;
    case (f)
      FMT_RGB:  r = FMT_RGB;
      FMT_YUY2: r = FMT_YUY2;
      default:  r = FMT_L8;
    endcase
    return r;
  endfunction

  // floor shift by 13, then clamp to 0..255
  function automatic logic [7:0] clamp_shr13(input logic signed [RGB_SUM_W-1:0] x);
    logic signed [RGB_SUM_W-1:0] s;
    logic [7:0] r;
    s = x >>> 13;
    if (s < 0) begin
      r = 8'd0;
    end else if (s > 255) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/pfc_yuv2rgb.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_yuv2rgb (
  input  wire logic [7:0]      y,
  input  wire logic [7:0]      u,
  input  wire logic [7:0]      v,
  output pfc_pkg::pixel_t      rgb
);
  import pfc_pkg::*;

  logic signed [8:0] ys, us, vs;
  logic signed [RGB_SUM_W-1:0] yy, r_sum, g_sum, b_sum;

  always_comb begin
    ys = $signed({1'b0, y}) - 9'sd16;
    us = $signed({1'b0, u}) - 9'sd128;
    vs = $signed({1'b0, v}) - 9'sd128;
    yy = RGB_SUM_W'(ys) * RGB_SUM_W'(K_Y);
    r_sum = yy + RGB_SUM_W'(vs) * RGB_SUM_W'(K_RV);
    g_sum = yy - RGB_SUM_W'(vs) * RGB_SUM_W'(K_GV) - RGB_SUM_W'(us) * RGB_SUM_W'(K_GU);
    b_sum = yy + RGB_SUM_W'(us) * RGB_SUM_W'(K_BU);
    rgb.c0 = clamp_shr13(r_sum);
    rgb.c1 = clamp_shr13(g_sum);
    rgb.c2 = clamp_shr13(b_sum);
  end

endmodule

`default_nettype wire

### hdl/pfc_rgb2yuv.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_rgb2yuv (
  input  wire logic [7:0] r,
  input  wire logic [7:0] g,
  input  wire logic [7:0] b,
  output logic [7:0]      y,
  output logic [7:0]      u,
  output logic [7:0]      v,
  output logic [7:0]      luma
);
  import pfc_pkg::*;

  logic [YUV_SUM_W-1:0] rw, gw, bw, y_sum, u_sum, v_sum;
  logic [12:0] l_sum;

  always_comb begin
    rw = YUV_SUM_W'(r);
    gw = YUV_SUM_W'(g);
    bw = YUV_SUM_W'(b);
    // subtractions may wrap mid-way; the final sums are never negative
    y_sum = rw * K_YR + gw * K_YG + bw * K_YB + OFS_Y;
    u_sum = bw * K_UB - rw * K_UR - gw * K_UG + OFS_UV;
    v_sum = rw * K_VR - gw * K_VG - bw * K_VB + OFS_UV;
    y = (y_sum[YUV_SUM_W-1:13] > Y_MAX) ? Y_MAX : y_sum[20:13];
    u = (u_sum[YUV_SUM_W-1:13] > UV_MAX) ? UV_MAX : u_sum[20:13];
    v = (v_sum[YUV_SUM_W-1:13] > UV_MAX) ? UV_MAX : v_sum[20:13];
    l_sum = 13'(r) * 13'd11 + 13'(g) * 13'd16 + 13'(b) * 13'd5;
    luma = l_sum[12:5];
  end

endmodule

`default_nettype wire

### hdl/pixel_format_converter.sv
// Converts a pixel stream between L8, RGB888 and YUY2 (BT.601, 13-bit fixed point).
// src_format and dst_format (0 L8, 1 RGB888, 2 YUY2, code 3 acts as L8) are set by the
// user through the cfg port while the block is idle; the block does not enforce it. An L8
// or RGB item is one pixel and gives one; a YUY2 item is a macropixel (y0,u,y1,v) and
// gives two, with pixel_count saying which. One item is taken every clock; its result
// passes an input register and a result register, with the whole conversion between them.
// The input stalls only when both registers are full and the result is held off.
// frame_start clears the U/V alternation used when writing YUY2 from single pixels.
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [1:0]                    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          frame_start,
  input  wire logic [7:0]                    byte0,
  input  wire logic [7:0]                    byte1,
  input  wire logic [7:0]                    byte2,
  input  wire logic [7:0]                    byte3,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         p0_c0,
  output logic [7:0]                         p0_c1,
  output logic [7:0]                         p0_c2,
  output logic [7:0]                         p1_c0,
  output logic [7:0]                         p1_c1,
  output logic [7:0]                         p1_c2,
  output logic [1:0]                         pixel_count
);
  import pfc_pkg::*;

  logic [1:0] src_format, dst_format;
  logic       parity, parity_next;

  // input register
  logic       v1;
  fmt_t       src1, dst1;
  logic       par1;
  logic [7:0] b0, b1, b2, b3;

  // result register
  logic       v2;
  pixel_t     p0, p1;
  logic [1:0] count;

  logic   in_take, adv;
  fmt_t   src_n;
  logic [7:0] r_in, g_in, b_in, y_c, u_c, v_c, luma_c;
  pixel_t rgb0, rgb1, p0_next, p1_next;
  logic [1:0] count_next;

  assign cfg_ready = 1'b1;
  assign adv       = !v2 || !out_stall;
  assign in_stall  = v1 && !adv;
  assign in_take   = in_valid && !in_stall;
  assign src_n     = norm_fmt(src_format);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_format <= FMT_L8;
      dst_format <= FMT_L8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_FORMAT: src_format <= cfg_data;
        CFG_DST_FORMAT: dst_format <= cfg_data;
        default: ;
      endcase
    end
  end

  // a macropixel steps the parity twice, so only single pixels flip it
  always_comb begin
    parity_next = frame_start ? 1'b0 : parity;
    if (src_n != FMT_YUY2) begin
      parity_next = ~parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      v1     <= 1'b0;
    end else begin
      if (in_take) begin
        parity <= parity_next;
        v1     <= 1'b1;
      end else if (adv) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      src1 <= src_n;
      dst1 <= norm_fmt(dst_format);
      par1 <= frame_start ? 1'b0 : parity;
      b0   <= byte0;
      b1   <= byte1;
      b2   <= byte2;
      b3   <= byte3;
    end
  end

  always_comb begin
    r_in = b0;
    g_in = (src1 == FMT_RGB) ? b1 : b0;
    b_in = (src1 == FMT_RGB) ? b2 : b0;
  end

  pfc_rgb2yuv u_rgb2yuv (
    .r    (r_in),
    .g    (g_in),
    .b    (b_in),
    .y    (y_c),
    .u    (u_c),
    .v    (v_c),
    .luma (luma_c)
  );

  pfc_yuv2rgb u_yuv2rgb0 (
    .y   (b0),
    .u   (b1),
    .v   (b3),
    .rgb (rgb0)
  );

  pfc_yuv2rgb u_yuv2rgb1 (
    .y   (b2),
    .u   (b1),
    .v   (b3),
    .rgb (rgb1)
  );

  always_comb begin
    p0_next    = '0;
    p1_next    = '0;
    count_next = PC_ONE;
    if (src1 == FMT_YUY2) begin
      count_next = PC_TWO;
      case (dst1)
        FMT_RGB: begin
          p0_next = rgb0;
          p1_next = rgb1;
        end
        FMT_YUY2: begin
          p0_next = '{c0: b0, c1: b1, c2: 8'd0};
          p1_next = '{c0: b2, c1: b3, c2: 8'd0};
        end
        default: begin
          p0_next.c0 = b0;
          p1_next.c0 = b2;
        end
      endcase
    end else begin
      case (dst1)
        FMT_RGB:  p0_next = '{c0: r_in, c1: g_in, c2: b_in};
        FMT_YUY2: p0_next = '{c0: y_c, c1: (par1 ? v_c : u_c), c2: 8'd0};
        default:  p0_next.c0 = luma_c;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      p0    <= p0_next;
      p1    <= p1_next;
      count <= count_next;
    end
  end

  assign out_valid   = v2;
  assign p0_c0       = p0.c0;
  assign p0_c1       = p0.c1;
  assign p0_c2       = p0.c2;
  assign p1_c0       = p1.c0;
  assign p1_c1       = p1.c1;
  assign p1_c2       = p1.c2;
  assign pixel_count = count;

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_count == PC_ONE || pixel_count == PC_TWO))
    else $error("pixel_count out of range");

  a_single_p1_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_count == PC_ONE |-> p1 == '0)
    else $error("second pixel not cleared for a single-pixel result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && out_stall)
    else $error("input stalled with room in the pipeline");

  a_frame_parity: assert property (@(posedge clk) disable iff (rst)
    in_take && frame_start && src_n != FMT_YUY2 |=> parity)
    else $error("parity not restarted by frame_start");

  a_yuy2_no_c2: assert property (@(posedge clk) disable iff (rst)
    $past(adv && v1 && dst1 == FMT_YUY2) |-> p0.c2 == 8'd0 && p1.c2 == 8'd0)
    else $error("third component set for a YUY2 target");

endmodule

`default_nettype wire

### test/pixel_format_converter_tb.sv
`timescale 1ns / 1ps

module pixel_format_converter_tb;
  import pfc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 8;
  localparam int RAND_PER_SET = 50;
  localparam logic [1:0] FMT_CODE3 = 2'd3;                  // undefined code, acts as L8
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;    // no register behind it

  typedef struct packed {
    logic       fs;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } pixel_item_t;

  typedef struct packed {
    pixel_t     p0;
    pixel_t     p1;
    logic [1:0] count;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic frame_start = 1'b0;
  logic [7:0] byte0 = '0;
  logic [7:0] byte1 = '0;
  logic [7:0] byte2 = '0;
  logic [7:0] byte3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] p0_c0, p0_c1, p0_c2, p1_c0, p1_c1, p1_c2;
  logic [1:0] pixel_count;

  pixel_format_converter u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .frame_start(frame_start),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .out_valid(out_valid), .out_stall(out_stall),
    .p0_c0(p0_c0), .p0_c1(p0_c1), .p0_c2(p0_c2),
    .p1_c0(p1_c0), .p1_c1(p1_c1), .p1_c2(p1_c2),
    .pixel_count(pixel_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_item_t   pixel_queue[$];
  pixel_result_t expected_pixels[$];

  // converter state as seen from the ports
  logic [1:0] src_reg = FMT_L8;
  logic [1:0] dst_reg = FMT_L8;
  logic       chroma_odd = 1'b0;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_on = 1'b0;
  int  hold_count = 0;
  bit  in_took = 1'b0;
  int  idle_cycles = 0;
  int  mismatches = 0;
  int  items_in = 0;
  int  results_seen = 0;

  function automatic fmt_t eff_format(input logic [1:0] code);
    if (code == FMT_RGB) return FMT_RGB;
    if (code == FMT_YUY2) return FMT_YUY2;
    return FMT_L8;
  endfunction

  // floor divide by 2^13, saturate to a byte
  function automatic logic [7:0] floor_clip(input int acc);
    int s;
    s = acc >>> 13;
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return 8'(s);
  endfunction

  function automatic pixel_t rgb_pixel(input fmt_t dst, input int r, input int g, input int b);
    pixel_t px;
    int y, u, v;
    px = '0;
    if (dst == FMT_RGB) begin
      px.c0 = 8'(r);
      px.c1 = 8'(g);
      px.c2 = 8'(b);
    end else if (dst == FMT_YUY2) begin
      // rounding term plus the 16 / 128 offsets, all in one constant
      y = (2104 * r + 4130 * g + 802 * b + 135168) >>> 13;
      u = (-1214 * r - 2384 * g + 3598 * b + 1052672) >>> 13;
      v = (3598 * r - 3013 * g - 585 * b + 1052672) >>> 13;
      px.c0 = 8'(y > 235 ? 235 : y);
      if (chroma_odd) px.c1 = 8'(v > 240 ? 240 : v);
      else px.c1 = 8'(u > 240 ? 240 : u);
    end else begin
      px.c0 = 8'((11 * r + 16 * g + 5 * b) >>> 5);
    end
    chroma_odd = ~chroma_odd;
    return px;
  endfunction

  function automatic pixel_t yuv_pixel(input fmt_t dst, input int y, input int u, input int v,
                                       input bit second);
    pixel_t px;
    int yy, uu, vv;
    px = '0;
    yy = 9535 * (y - 16);
    uu = u - 128;
    vv = v - 128;
    if (dst == FMT_RGB) begin
      px.c0 = floor_clip(yy + 13074 * vv);
      px.c1 = floor_clip(yy - 6660 * vv - 3203 * uu);
      px.c2 = floor_clip(yy + 16531 * uu);
    end else if (dst == FMT_YUY2) begin
      px.c0 = 8'(y);
      px.c1 = second ? 8'(v) : 8'(u);
    end else begin
      px.c0 = 8'(y);
    end
    chroma_odd = ~chroma_odd;
    return px;
  endfunction

  function automatic pixel_result_t convert_item(input pixel_item_t it);
    pixel_result_t res;
    fmt_t src, dst;
    src = eff_format(src_reg);
    dst = eff_format(dst_reg);
    res = '0;
    if (it.fs) chroma_odd = 1'b0;
    if (src == FMT_YUY2) begin
      res.p0 = yuv_pixel(dst, int'(it.b0), int'(it.b1), int'(it.b3), 1'b0);
      res.p1 = yuv_pixel(dst, int'(it.b2), int'(it.b1), int'(it.b3), 1'b1);
      res.count = PC_TWO;
    end else begin
      if (src == FMT_RGB) res.p0 = rgb_pixel(dst, int'(it.b0), int'(it.b1), int'(it.b2));
      else res.p0 = rgb_pixel(dst, int'(it.b0), int'(it.b0), int'(it.b0));
      res.count = PC_ONE;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // sender
  always @(negedge clk) begin : drive
    pixel_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pixel_queue.pop_front();
        frame_start <= it.fs;
        byte0 <= it.b0;
        byte1 <= it.b1;
        byte2 <= it.b2;
        byte3 <= it.b3;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver; the long hold-off is counted here
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_on && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : observe
    pixel_result_t want;
    bit moved;
    if (rst) begin
      in_took <= 1'b0;
      src_reg = FMT_L8;
      dst_reg = FMT_L8;
      chroma_odd = 1'b0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      in_took <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_SRC_FORMAT: src_reg = cfg_data;
          CFG_DST_FORMAT: dst_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        expected_pixels.push_back(convert_item({frame_start, byte0, byte1, byte2, byte3}));
        items_in++;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        if (expected_pixels.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("p0_c0", want.p0.c0, p0_c0);
          check_field("p0_c1", want.p0.c1, p0_c1);
          check_field("p0_c2", want.p0.c2, p0_c2);
          check_field("p1_c0", want.p1.c0, p1_c0);
          check_field("p1_c1", want.p1.c1, p1_c1);
          check_field("p1_c2", want.p1.c2, p1_c2);
          check_field("pixel_count", 8'(want.count), 8'(pixel_count));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("pixel_format_converter regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_formats(input logic [1:0] s, input logic [1:0] d);
    drain();
    write_reg(CFG_SRC_FORMAT, s);
    write_reg(CFG_DST_FORMAT, d);
  endtask

  task automatic queue_pixel(input logic fs, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d);
    pixel_queue.push_back({fs, a, b, c, d});
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int ph;
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: clamping corners, parity, replication, pass-through
    set_formats(FMT_YUY2, FMT_RGB);
    queue_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(1'b0, 8'd16, 8'd128, 8'd235, 8'd128);
    queue_pixel(1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF);
    queue_pixel(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00);
    set_formats(FMT_RGB, FMT_YUY2);
    queue_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hA5);
    queue_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h5A);
    queue_pixel(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00);
    queue_pixel(1'b1, 8'h00, 8'h00, 8'hFF, 8'hFF);
    set_formats(FMT_L8, FMT_RGB);
    queue_pixel(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00);
    set_formats(FMT_L8, FMT_YUY2);
    queue_pixel(1'b1, 8'hFF, 8'h12, 8'h34, 8'h56);
    queue_pixel(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    set_formats(FMT_RGB, FMT_L8);
    queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    queue_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
    set_formats(FMT_YUY2, FMT_YUY2);
    queue_pixel(1'b0, 8'h11, 8'h22, 8'h33, 8'h44);
    set_formats(FMT_YUY2, FMT_L8);
    queue_pixel(1'b0, 8'hEE, 8'h22, 8'h33, 8'h44);
    set_formats(FMT_RGB, FMT_RGB);
    queue_pixel(1'b0, 8'h12, 8'h34, 8'h56, 8'h78);
    set_formats(FMT_L8, FMT_L8);
    queue_pixel(1'b0, 8'h9C, 8'h34, 8'h56, 8'h78);
    set_formats(FMT_CODE3, FMT_RGB);
    queue_pixel(1'b0, 8'h80, 8'h01, 8'h02, 8'h03);
    set_formats(FMT_RGB, FMT_CODE3);
    queue_pixel(1'b0, 8'h80, 8'h40, 8'hC0, 8'h03);
    // a write to the spare index must leave both formats alone
    drain();
    write_reg(CFG_IDX_SPARE, FMT_YUY2);
    queue_pixel(1'b0, 8'h10, 8'hF0, 8'h70, 8'h03);

    // random: every src/dst code pair, idle profile rotating across them
    for (ph = 0; ph < 16; ph++) begin
      set_formats(2'(ph / 4), 2'(ph % 4));
      case ((ph + ph / 4) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (ph == 0) begin
        // output held off while the sender keeps offering: pipeline backs up
        send_idle_pct = 0;
        hold_on = 1'b1;
      end
      for (n = 0; n < RAND_PER_SET; n++) begin
        if (ph == 1 && n == RAND_PER_SET / 2) drain();
        queue_pixel($urandom_range(15) == 0, pick_byte(), pick_byte(), pick_byte(),
                    pick_byte());
      end
    end

    drain();
    $display("%0d pixel transactions sent, %0d results checked", items_in, results_seen);
    $display("all 16 source/target format codes, frame restarts, stalls on both sides");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("pixel_format_converter regression: pass");
    end else begin
      $display("pixel_format_converter regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pfc_pkg.sv
hdl/pfc_yuv2rgb.sv
hdl/pfc_rgb2yuv.sv
hdl/pixel_format_converter.sv
test/pixel_format_converter_tb.sv
